[hdl/vmr_pkg.sv]
// Package: shared types, codes and reset values for the volume mute ramp.
package vmr_pkg;

   localparam int VOL_W   = 16;
   localparam int DELAY_W = 10;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 16;

   // Register indexes on the configuration port
   localparam logic [IDX_W-1:0] CSR_RANGE_MIN    = 3'd0;
   localparam logic [IDX_W-1:0] CSR_RANGE_MAX    = 3'd1;
   localparam logic [IDX_W-1:0] CSR_STEP_SIZE    = 3'd2;
   localparam logic [IDX_W-1:0] CSR_DELAY_SLOW   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_DELAY_MEDIUM = 3'd4;
   localparam logic [IDX_W-1:0] CSR_DELAY_FAST   = 3'd5;

   // Register reset values
   localparam logic [VOL_W-1:0]   RST_RANGE_MIN    = 16'd0;
   localparam logic [VOL_W-1:0]   RST_RANGE_MAX    = 16'd255;
   localparam logic [VOL_W-1:0]   RST_STEP_SIZE    = 16'd12;
   localparam logic [DELAY_W-1:0] RST_DELAY_SLOW   = 10'd15;
   localparam logic [DELAY_W-1:0] RST_DELAY_MEDIUM = 10'd30;
   localparam logic [DELAY_W-1:0] RST_DELAY_FAST   = 10'd45;

   // Request opcodes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_MUTE   = 2'd1;
   localparam logic [1:0] OP_UNMUTE = 2'd2;
   localparam logic [1:0] OP_STOP   = 2'd3;

   // Speed codes
   localparam logic [1:0] SPEED_SLOW   = 2'd0;
   localparam logic [1:0] SPEED_MEDIUM = 2'd1;
   localparam logic [1:0] SPEED_FAST   = 2'd2;
   localparam logic [1:0] SPEED_SAT    = 2'd3;

   // Mode codes as reported on the result channel
   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_MUTING   = 2'd1;
   localparam logic [1:0] MODE_UNMUTING = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'b001,
      ST_MUTING   = 3'b010,
      ST_UNMUTING = 3'b100
   } ramp_state_type;

   typedef struct packed {
      logic [VOL_W-1:0]   range_min;
      logic [VOL_W-1:0]   range_max;
      logic [VOL_W-1:0]   step_size;
      logic [DELAY_W-1:0] delay_slow;
      logic [DELAY_W-1:0] delay_medium;
      logic [DELAY_W-1:0] delay_fast;
   } cfg_type;

   function automatic logic [1:0] mode_code(input ramp_state_type st);
      logic [1:0] m;
      begin
         case (st)
            ST_MUTING:   m = MODE_MUTING;
            ST_UNMUTING: m = MODE_UNMUTING;
            default:     m = MODE_IDLE;
         endcase
         return m;
      end
   endfunction

endpackage

[hdl/vmr_if.sv]
// Interfaces: request and result channels of the volume mute ramp.
interface vmr_req_if
   import vmr_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [1:0]       speed;
   logic [VOL_W-1:0] present_volume;

   modport source (output valid, output op, output speed, output present_volume,
                   input ready);
   modport sink   (input valid, input op, input speed, input present_volume,
                   output ready);
endinterface

interface vmr_rsp_if
   import vmr_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [VOL_W-1:0] volume;
   logic             volume_write;
   logic             ramp_finished;
   logic [1:0]       ramp_mode;

   modport source (output valid, output volume, output volume_write,
                   output ramp_finished, output ramp_mode, input ready);
   modport sink   (input valid, input volume, input volume_write,
                   input ramp_finished, input ramp_mode, output ready);
endinterface

[hdl/vmr_csr.sv]
// Configuration register bank of the volume mute ramp.
module vmr_csr
   import vmr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the register copy
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RANGE_MIN:    cfg_in.range_min    = csr_wdata[VOL_W-1:0];
            CSR_RANGE_MAX:    cfg_in.range_max    = csr_wdata[VOL_W-1:0];
            CSR_STEP_SIZE:    cfg_in.step_size    = csr_wdata[VOL_W-1:0];
            CSR_DELAY_SLOW:   cfg_in.delay_slow   = csr_wdata[DELAY_W-1:0];
            CSR_DELAY_MEDIUM: cfg_in.delay_medium = csr_wdata[DELAY_W-1:0];
            CSR_DELAY_FAST:   cfg_in.delay_fast   = csr_wdata[DELAY_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min    <= RST_RANGE_MIN;
         cfg_ff.range_max    <= RST_RANGE_MAX;
         cfg_ff.step_size    <= RST_STEP_SIZE;
         cfg_ff.delay_slow   <= RST_DELAY_SLOW;
         cfg_ff.delay_medium <= RST_DELAY_MEDIUM;
         cfg_ff.delay_fast   <= RST_DELAY_FAST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/vmr_core.sv]
// Ramp state, step arithmetic and result register of the volume mute ramp.
module vmr_core
   import vmr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   vmr_req_if.sink   req,
   vmr_rsp_if.source rsp
);

   ramp_state_type     state_ff, state_in;
   logic [VOL_W-1:0]   volume_ff, volume_in;
   logic [1:0]         speed_ff, speed_in;
   logic [DELAY_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VOL_W-1:0]   rsp_volume_ff;
   logic               rsp_write_ff, rsp_write_in;
   logic               rsp_finished_ff, rsp_finished_in;
   logic [1:0]         rsp_mode_ff;

   logic               accept;
   logic [1:0]         req_speed;
   logic [DELAY_W-1:0] delay_sel;
   logic [DELAY_W-1:0] period;
   logic [DELAY_W-1:0] count_inc;
   logic [VOL_W:0]     floor_sum;
   logic [VOL_W:0]     up_sum;
   logic [VOL_W-1:0]   vol_down;
   logic [VOL_W-1:0]   vol_up;
   logic [VOL_W-1:0]   vol_step;
   logic               at_bound;
   ramp_state_type     dir;

   // Result register frees up when taken; a new transfer can land the same cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Speed code 3 behaves as fast
   assign req_speed = (req.speed == SPEED_SAT) ? SPEED_FAST : req.speed;

   // Step period of the active speed, zero acts as one
   always_comb begin
      case (speed_ff)
         SPEED_SLOW:   delay_sel = cfg.delay_slow;
         SPEED_MEDIUM: delay_sel = cfg.delay_medium;
         default:      delay_sel = cfg.delay_fast;
      endcase
   end
   assign period    = (delay_sel == '0) ? DELAY_W'(1) : delay_sel;
   assign count_inc = count_ff + DELAY_W'(1);

   // Clamped step in both directions
   assign floor_sum = {1'b0, cfg.range_min} + {1'b0, cfg.step_size};
   assign vol_down  = ({1'b0, volume_ff} >= floor_sum) ? (volume_ff - cfg.step_size)
                                                       : cfg.range_min;
   assign up_sum    = {1'b0, volume_ff} + {1'b0, cfg.step_size};
   assign vol_up    = (up_sum > {1'b0, cfg.range_max}) ? cfg.range_max
                                                       : up_sum[VOL_W-1:0];
   assign vol_step  = (state_ff == ST_MUTING) ? vol_down : vol_up;
   assign at_bound  = (state_ff == ST_MUTING) ? (vol_step == cfg.range_min)
                                              : (vol_step == cfg.range_max);

   assign dir = (req.op == OP_MUTE) ? ST_MUTING : ST_UNMUTING;

   // Next state for one item
   always_comb begin
      state_in        = state_ff;
      volume_in       = volume_ff;
      speed_in        = speed_ff;
      count_in        = count_ff;
      rsp_write_in    = 1'b0;
      rsp_finished_in = 1'b0;
      case (req.op)
         OP_TICK: begin
            if (state_ff != ST_IDLE) begin
               count_in = count_inc;
               if (count_inc >= period) begin
                  count_in     = '0;
                  volume_in    = vol_step;
                  rsp_write_in = 1'b1;
                  if (at_bound) begin
                     state_in        = ST_IDLE;
                     rsp_finished_in = 1'b1;
                  end
               end
            end
         end
         OP_MUTE, OP_UNMUTE: begin
            state_in = dir;
            if (state_ff == ST_IDLE) begin
               volume_in = req.present_volume;
               speed_in  = req_speed;
               count_in  = '0;
            end else if (speed_ff != req_speed) begin
               speed_in = req_speed;
               count_in = '0;
            end
         end
         default: begin
            if (state_ff != ST_IDLE) begin
               state_in        = ST_IDLE;
               count_in        = '0;
               rsp_finished_in = 1'b1;
            end
         end
      endcase
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control and ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         volume_ff    <= '0;
         speed_ff     <= SPEED_SLOW;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff  <= state_in;
            volume_ff <= volume_in;
            speed_ff  <= speed_in;
            count_ff  <= count_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_volume_ff   <= volume_in;
         rsp_write_ff    <= rsp_write_in;
         rsp_finished_ff <= rsp_finished_in;
         rsp_mode_ff     <= mode_code(state_in);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.volume        = rsp_volume_ff;
   assign rsp.volume_write  = rsp_write_ff;
   assign rsp.ramp_finished = rsp_finished_ff;
   assign rsp.ramp_mode     = rsp_mode_ff;

`ifndef ASSERT_OFF
   // Period counter rests at zero while no ramp runs
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff == '0))
      else $error("period counter nonzero while idle");

   // A finished ramp always reports idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_finished_ff) |-> (rsp_mode_ff == MODE_IDLE))
      else $error("ramp finished but mode not idle");

   // Only a tick can step the volume
   a_write_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.op != OP_TICK)) |=> !rsp_write_ff)
      else $error("volume step on a non-tick item");

   // Input is held off only by a pending, untaken result
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp_valid_ff && !rsp.ready))
      else $error("input stalled without a pending result");
`endif

endmodule

[hdl/volume_mute_ramp.sv]
// Top level of the volume mute ramp: register bank and ramp core.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    op, speed, present_volume
//   rsp_chan  out        valid/ready    volume, volume_write, ramp_finished, ramp_mode
//   csr_*     in         write enable   csr_index, csr_wdata
//
// One item per cycle unless a result stalls; its result is registered in the cycle
// after the transfer. The ramp state update is a single clamped add or subtract.
// The result register lets a new item in while the held result is taken.
// A stalled result blocks input only until rsp_chan.ready returns.
// Reset is synchronous and restores register defaults and the idle state.
module volume_mute_ramp
   import vmr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   vmr_req_if.sink          req_chan,
   vmr_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cfg_type cfg;

   // Configuration registers
   vmr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Ramp datapath and result register
   vmr_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule
